// ===== hw/rtl/rbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rbs_pkg;

   // ray word in, result word out
   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] entry_distance;
   } rsp_type;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // reciprocal: 2^32 / |d|, one quotient bit per step
   localparam int DIV_STEPS          = 33;
   localparam int DIV_STEP_PER_STAGE = 4;
   localparam int DIV_STAGES         = (DIV_STEPS + DIV_STEP_PER_STAGE - 1) / DIV_STEP_PER_STAGE;
   localparam int RECIP_LATENCY      = DIV_STAGES + 2;
   localparam int SLAB_LATENCY       = 4;
   localparam int TOTAL_LATENCY      = RECIP_LATENCY + SLAB_LATENCY + 2;

   // register indexes
   localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
   localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
   localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
   localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
   localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
   localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/rbs_recip.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbs_recip
   import rbs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic signed [31:0] dir,
   output logic signed [31:0]      recip
);

   logic [32:0] mag_ff  [0:DIV_STAGES];
   logic [32:0] rem_ff  [0:DIV_STAGES];
   logic [32:0] quo_ff  [0:DIV_STAGES];
   logic        neg_ff  [0:DIV_STAGES];
   logic        zero_ff [0:DIV_STAGES];
   logic signed [31:0] recip_ff;
   logic signed [31:0] recip_in;
   logic [32:0] dir_ext;

   assign dir_ext = {dir[31], dir};

   // input stage: magnitude and sign
   always_ff @(posedge clock) begin
      mag_ff[0]  <= dir[31] ? (33'd0 - dir_ext) : dir_ext;
      rem_ff[0]  <= '0;
      quo_ff[0]  <= '0;
      neg_ff[0]  <= dir[31];
      zero_ff[0] <= (dir == '0);
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [32:0] rem_in;
      logic [32:0] quo_in;

      always_comb begin
         logic [32:0] rem_sh;
         rem_in = rem_ff[s];
         quo_in = quo_ff[s];
         for (int j = 0; j < DIV_STEP_PER_STAGE; j++) begin
            if (s * DIV_STEP_PER_STAGE + j < DIV_STEPS) begin
               // dividend is 2^32: only the first bit brought down is one
               rem_sh = {rem_in[31:0], (s * DIV_STEP_PER_STAGE + j == 0)};
               if (rem_sh >= mag_ff[s]) begin
                  rem_in = rem_sh - mag_ff[s];
                  quo_in = {quo_in[31:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_in[31:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         mag_ff[s+1]  <= mag_ff[s];
         rem_ff[s+1]  <= rem_in;
         quo_ff[s+1]  <= quo_in;
         neg_ff[s+1]  <= neg_ff[s];
         zero_ff[s+1] <= zero_ff[s];
      end
   end

   // sign and saturation
   always_comb begin
      if (zero_ff[DIV_STAGES]) begin
         recip_in = Q_MAX;
      end else if (neg_ff[DIV_STAGES]) begin
         if (quo_ff[DIV_STAGES] > 33'h0_8000_0000) begin
            recip_in = Q_MIN;
         end else begin
            recip_in = 32'(33'd0 - quo_ff[DIV_STAGES]);
         end
      end else if (quo_ff[DIV_STAGES] > 33'h0_7FFF_FFFF) begin
         recip_in = Q_MAX;
      end else begin
         recip_in = quo_ff[DIV_STAGES][31:0];
      end
   end

   always_ff @(posedge clock) begin
      recip_ff <= recip_in;
   end

   assign recip = recip_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rbs_slab.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbs_slab
   import rbs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic signed [31:0] corner_lo,
   input  wire logic signed [31:0] corner_hi,
   input  wire logic signed [31:0] origin,
   input  wire logic signed [31:0] recip,
   output logic signed [31:0]      t_near,
   output logic signed [31:0]      t_far
);

   logic signed [31:0] diff_lo_ff, diff_hi_ff, recip_ff;
   logic signed [63:0] prod_lo_ff, prod_hi_ff;
   logic signed [31:0] dist_lo_ff, dist_hi_ff;
   logic signed [31:0] near_ff, far_ff;
   logic signed [32:0] sub_lo, sub_hi;
   logic signed [63:0] sh_lo, sh_hi;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      if (v > 33'sh0_7FFF_FFFF) begin
         return Q_MAX;
      end else if (v < -33'sh0_8000_0000) begin
         return Q_MIN;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) begin
         return Q_MAX;
      end else if (v < -64'sh8000_0000) begin
         return Q_MIN;
      end
      return v[31:0];
   endfunction

   assign sub_lo = 33'(corner_lo) - 33'(origin);
   assign sub_hi = 33'(corner_hi) - 33'(origin);
   // arithmetic shift rounds toward minus infinity
   assign sh_lo  = prod_lo_ff >>> 16;
   assign sh_hi  = prod_hi_ff >>> 16;

   always_ff @(posedge clock) begin
      diff_lo_ff <= sat33(sub_lo);
      diff_hi_ff <= sat33(sub_hi);
      recip_ff   <= recip;
      prod_lo_ff <= 64'(diff_lo_ff) * 64'(recip_ff);
      prod_hi_ff <= 64'(diff_hi_ff) * 64'(recip_ff);
      dist_lo_ff <= sat64(sh_lo);
      dist_hi_ff <= sat64(sh_hi);
      near_ff    <= (dist_lo_ff < dist_hi_ff) ? dist_lo_ff : dist_hi_ff;
      far_ff     <= (dist_lo_ff > dist_hi_ff) ? dist_lo_ff : dist_hi_ff;
   end

   assign t_near = near_ff;
   assign t_far  = far_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ray_box_slab_intersect_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// ray versus axis-aligned box slab test, signed Q16.16
//
// input channel: a ray word (origin, direction) on req_data is taken at a
// clock edge where start is high and busy is low; busy is always low, so a
// ray may be offered every cycle
// result channel: rsp_valid is high for one cycle with hit and the entry
// distance on rsp_data; entry_distance reads zero on a miss
// the receiver cannot stall the result channel, and the pipeline never stops
// rsp_valid rises together with the result word once the ray has passed
// through every stage below, its valid bit carried alongside it
// throughput: one ray per cycle; the stages are the pipelined reciprocal
// divider (input register, nine divide stages of up to four quotient bits
// each, output register), four slab stages (difference, multiply, shift
// and saturate, min/max) and two stages that combine the axes and decide hit
// configuration: apb-style port, box corners at byte addresses 0 to 20,
// pready always high; write only while no ray is in flight
// reset: synchronous, clears the in-flight valid bits and the box corners to 0

module ray_box_slab_intersect_core
   import rbs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // ray input
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   // result output
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   // configuration
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // box corner registers
   logic signed [31:0] box_ff [0:5];
   logic [2:0] reg_sel;

   assign reg_sel = paddr[4:2];
   assign pready  = 1'b1;
   assign busy    = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            box_ff[i] <= '0;
         end
      end else if (psel && penable && pwrite) begin
         case (reg_sel)
            REG_BOX_MIN_X: box_ff[0] <= pwdata;
            REG_BOX_MIN_Y: box_ff[1] <= pwdata;
            REG_BOX_MIN_Z: box_ff[2] <= pwdata;
            REG_BOX_MAX_X: box_ff[3] <= pwdata;
            REG_BOX_MAX_Y: box_ff[4] <= pwdata;
            REG_BOX_MAX_Z: box_ff[5] <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_BOX_MIN_X: prdata = box_ff[0];
         REG_BOX_MIN_Y: prdata = box_ff[1];
         REG_BOX_MIN_Z: prdata = box_ff[2];
         REG_BOX_MAX_X: prdata = box_ff[3];
         REG_BOX_MAX_Y: prdata = box_ff[4];
         REG_BOX_MAX_Z: prdata = box_ff[5];
         default:       prdata = '0;
      endcase
   end

   // valid bits travel with the word through every stage
   logic accept;
   logic valid_ff [0:TOTAL_LATENCY-1];

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_LATENCY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept;
         for (int i = 1; i < TOTAL_LATENCY; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // origins wait alongside the divider
   logic signed [31:0] ox_ff [0:RECIP_LATENCY-1];
   logic signed [31:0] oy_ff [0:RECIP_LATENCY-1];
   logic signed [31:0] oz_ff [0:RECIP_LATENCY-1];

   always_ff @(posedge clock) begin
      ox_ff[0] <= req_data.origin_x;
      oy_ff[0] <= req_data.origin_y;
      oz_ff[0] <= req_data.origin_z;
      for (int i = 1; i < RECIP_LATENCY; i++) begin
         ox_ff[i] <= ox_ff[i-1];
         oy_ff[i] <= oy_ff[i-1];
         oz_ff[i] <= oz_ff[i-1];
      end
   end

   // per-axis reciprocal
   logic signed [31:0] rx, ry, rz;

   rbs_recip u_recip_x (.clock(clock), .dir(req_data.dir_x), .recip(rx));
   rbs_recip u_recip_y (.clock(clock), .dir(req_data.dir_y), .recip(ry));
   rbs_recip u_recip_z (.clock(clock), .dir(req_data.dir_z), .recip(rz));

   // per-axis slab distances
   logic signed [31:0] nx, fx, ny, fy, nz, fz;

   rbs_slab u_slab_x (
      .clock(clock), .corner_lo(box_ff[0]), .corner_hi(box_ff[3]),
      .origin(ox_ff[RECIP_LATENCY-1]), .recip(rx), .t_near(nx), .t_far(fx)
   );
   rbs_slab u_slab_y (
      .clock(clock), .corner_lo(box_ff[1]), .corner_hi(box_ff[4]),
      .origin(oy_ff[RECIP_LATENCY-1]), .recip(ry), .t_near(ny), .t_far(fy)
   );
   rbs_slab u_slab_z (
      .clock(clock), .corner_lo(box_ff[2]), .corner_hi(box_ff[5]),
      .origin(oz_ff[RECIP_LATENCY-1]), .recip(rz), .t_near(nz), .t_far(fz)
   );

   // entry is the latest near plane, exit the earliest far plane
   logic signed [31:0] t_in_ff, t_out_ff, t_in_in, t_out_in, near_xy, far_xy;

   assign near_xy  = (nx > ny) ? nx : ny;
   assign t_in_in  = (near_xy > nz) ? near_xy : nz;
   assign far_xy   = (fx < fy) ? fx : fy;
   assign t_out_in = (far_xy < fz) ? far_xy : fz;

   always_ff @(posedge clock) begin
      t_in_ff  <= t_in_in;
      t_out_ff <= t_out_in;
   end

   // hit decision and output register
   logic    hit_in;
   rsp_type rsp_ff;

   assign hit_in = !t_out_ff[31] && !(t_in_ff > t_out_ff);

   always_ff @(posedge clock) begin
      rsp_ff.hit            <= hit_in;
      rsp_ff.entry_distance <= hit_in ? t_in_ff : '0;
   end

   assign rsp_valid = valid_ff[TOTAL_LATENCY-1];
   assign rsp_data  = rsp_ff;

   // every accepted ray raises rsp_valid once it has passed the whole pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##TOTAL_LATENCY rsp_valid)
      else $error("result missing after accepted ray");

   // a miss reports a zero distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.entry_distance == '0)
      else $error("miss with nonzero distance");

   // a hit never exits behind the ray origin
   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      valid_ff[TOTAL_LATENCY-2] && hit_in |=> rsp_data.hit && !$past(t_out_ff[31]))
      else $error("hit with negative exit distance");

endmodule

`default_nettype wire
